### sv/bole_pkg.sv
// Shared types, codes and helpers for the bounded ordered list engine.
package bole_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;

    // Operation codes carried in the opcode field
    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_END   = 4'd1;
    localparam logic [3:0] OP_INS_AT    = 4'd2;
    localparam logic [3:0] OP_DEL_FRONT = 4'd3;
    localparam logic [3:0] OP_DEL_END   = 4'd4;
    localparam logic [3:0] OP_DEL_AT    = 4'd5;
    localparam logic [3:0] OP_DEL_VALUE = 4'd6;
    localparam logic [3:0] OP_SEARCH    = 4'd7;
    localparam logic [3:0] OP_SORT      = 4'd8;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_OOB      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_SORT
    } cell_mode_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        cell_mode_t          mode;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    count;
        logic                phase;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

    // Result word, status in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] found_index;
        logic [2:0]       status;
    } result_t;

    function automatic logic greater_signed(input logic [DATA_W-1:0] a,
                                            input logic [DATA_W-1:0] b);
        greater_signed = $signed(a) > $signed(b);
    endfunction

endpackage

### sv/bole_cell.sv
// One storage cell of the list row: shift, load or compare-swap with its neighbours.
module bole_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  bole_pkg::cell_ctrl_t           ctrl,
    input  logic [bole_pkg::DATA_W-1:0]    left_data,
    input  logic [bole_pkg::DATA_W-1:0]    right_data,
    output logic [bole_pkg::DATA_W-1:0]    data
);

    localparam logic [bole_pkg::POS_W-1:0] IDX_POS    = bole_pkg::POS_W'(IDX);
    localparam logic                       IDX_PARITY = 1'(IDX % 2);

    logic [bole_pkg::DATA_W-1:0] data_reg;
    logic [bole_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            bole_pkg::CM_INSERT:
            begin
                // open a gap at pos: cells above take their left neighbour
                if (IDX_POS > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (IDX_POS == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
            end
            bole_pkg::CM_DELETE:
            begin
                if (IDX_POS >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            bole_pkg::CM_SORT:
            begin
                if (ctrl.phase == IDX_PARITY)
                begin
                    // lower cell of a pair keeps the minimum
                    if ((IDX_POS + 8'd1 < ctrl.count) &&
                        bole_pkg::greater_signed(data_reg, right_data))
                    begin
                        data_next = right_data;
                    end
                end
                else
                begin
                    // upper cell of a pair keeps the maximum
                    if ((IDX_POS != '0) && (IDX_POS < ctrl.count) &&
                        bole_pkg::greater_signed(left_data, data_reg))
                    begin
                        data_next = left_data;
                    end
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/bounded_ordered_list_engine_top.sv
// Bounded ordered list engine: a row of value cells with a small sequencer.
// Insert, delete and the immediate error cases finish on transfer; the result goes into the result buffer.
// Search and delete-by-value: match bits captured on transfer, then scanned upward from index 0.
// Sort: length odd-even transposition passes through the cell row, one pass a cycle.
// A two-entry result buffer lets a new item transfer while one result waits downstream.
// rst_n (asynchronous, active low) empties the list and the result buffer; cell contents are not cleared.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] opcode, [35:4] value, [43:36] position, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [10:3] found_index, [18:11] length, [23:19] zero
    output logic [23:0] m_axis_tdata
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IXW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_SORT = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [IXW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                  pass_reg, pass_next;
    logic                           scan_del_reg, scan_del_next;
    logic [CAPACITY-1:0]            match_reg, match_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           skid_valid_reg, skid_valid_next;
    bole_pkg::result_t              out_data_reg, out_data_next;
    bole_pkg::result_t              skid_data_reg, skid_data_next;

    logic                           push;
    bole_pkg::result_t              push_data;
    bole_pkg::cell_ctrl_t           ctrl;
    logic                           in_xfer;
    logic                           out_free;

    logic [3:0]                     in_opcode;
    logic [bole_pkg::DATA_W-1:0]    in_value;
    logic [bole_pkg::POS_W-1:0]     in_position;
    logic [bole_pkg::POS_W-1:0]     count_pos;

    logic [bole_pkg::DATA_W-1:0]    cell_data [CAPACITY];

    assign in_opcode   = s_axis_tdata[3:0];
    assign in_value    = s_axis_tdata[35:4];
    assign in_position = s_axis_tdata[43:36];
    assign count_pos   = bole_pkg::POS_W'(count_reg);

    // Accept only from idle, and only while a spare result slot remains
    assign s_axis_tready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Row of cells; the ends see their own data or zero beyond the row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [bole_pkg::DATA_W-1:0] left_d;
        logic [bole_pkg::DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        bole_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // Per-cell match flags, masked to the live part of the list
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (cell_data[i] == in_value) && (CW'(i) < count_reg);
        end
    end

    // Sequencer: decode on transfer, then step through a scan or a sort
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        scan_del_next = scan_del_reg;
        push          = 1'b0;
        push_data     = '{length: count_pos, found_index: '0, status: bole_pkg::ST_OK};
        ctrl          = '{mode: bole_pkg::CM_HOLD, pos: '0, count: count_pos,
                          phase: 1'b0, value: in_value};

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    push = 1'b1;
                    case (in_opcode)
                        bole_pkg::OP_INS_FRONT,
                        bole_pkg::OP_INS_END,
                        bole_pkg::OP_INS_AT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                push_data.status = bole_pkg::ST_FULL;
                            end
                            else if ((in_opcode == bole_pkg::OP_INS_AT) &&
                                     (in_position > count_pos))
                            begin
                                push_data.status = bole_pkg::ST_OOB;
                            end
                            else
                            begin
                                ctrl.mode = bole_pkg::CM_INSERT;
                                if (in_opcode == bole_pkg::OP_INS_FRONT)
                                begin
                                    ctrl.pos = '0;
                                end
                                else if (in_opcode == bole_pkg::OP_INS_END)
                                begin
                                    ctrl.pos = count_pos;
                                end
                                else
                                begin
                                    ctrl.pos = in_position;
                                end
                                count_next       = count_reg + CW'(1);
                                push_data.length = count_pos + 8'd1;
                            end
                        end
                        bole_pkg::OP_DEL_FRONT,
                        bole_pkg::OP_DEL_END,
                        bole_pkg::OP_DEL_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                push_data.status = bole_pkg::ST_EMPTY;
                            end
                            else if ((in_opcode == bole_pkg::OP_DEL_AT) &&
                                     (in_position >= count_pos))
                            begin
                                push_data.status = bole_pkg::ST_OOB;
                            end
                            else
                            begin
                                ctrl.mode = bole_pkg::CM_DELETE;
                                if (in_opcode == bole_pkg::OP_DEL_FRONT)
                                begin
                                    ctrl.pos = '0;
                                end
                                else if (in_opcode == bole_pkg::OP_DEL_END)
                                begin
                                    ctrl.pos = count_pos - 8'd1;
                                end
                                else
                                begin
                                    ctrl.pos = in_position;
                                end
                                count_next       = count_reg - CW'(1);
                                push_data.length = count_pos - 8'd1;
                            end
                        end
                        bole_pkg::OP_DEL_VALUE,
                        bole_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                push_data.status = (in_opcode == bole_pkg::OP_DEL_VALUE) ?
                                                   bole_pkg::ST_EMPTY : bole_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                // hold the result until the scan resolves
                                push          = 1'b0;
                                idx_next      = '0;
                                scan_del_next = (in_opcode == bole_pkg::OP_DEL_VALUE);
                                state_next    = S_SCAN;
                            end
                        end
                        bole_pkg::OP_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                push       = 1'b0;
                                pass_next  = '0;
                                state_next = S_SORT;
                            end
                        end
                        default:
                        begin
                            push_data.status = bole_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match_reg[idx_reg])
                begin
                    push                  = 1'b1;
                    push_data.found_index = bole_pkg::POS_W'(idx_reg);
                    if (scan_del_reg)
                    begin
                        ctrl.mode        = bole_pkg::CM_DELETE;
                        ctrl.pos         = bole_pkg::POS_W'(idx_reg);
                        count_next       = count_reg - CW'(1);
                        push_data.length = count_pos - 8'd1;
                    end
                    state_next = S_IDLE;
                end
                else if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    push             = 1'b1;
                    push_data.status = bole_pkg::ST_NOTFOUND;
                    state_next       = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IXW'(1);
                end
            end
            S_SORT:
            begin
                ctrl.mode  = bole_pkg::CM_SORT;
                ctrl.phase = pass_reg[0];
                if (pass_reg + CW'(1) == count_reg)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pass_next = pass_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Two-slot result buffer: output register plus a spare behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload and scratch registers: no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pass_reg      <= pass_next;
        scan_del_reg  <= scan_del_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (in_xfer)
        begin
            match_reg <= match_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

endmodule

### sv/bole_checker.sv
// Port-level checks on the result stream of the list engine, bound to the top level.
module bole_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled transfer holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:11] <= 8'(CAPACITY)))
        else $error("length above capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == bole_pkg::ST_FULL)
        |-> (m_axis_tdata[18:11] == 8'(CAPACITY)))
        else $error("full status with spare room");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == bole_pkg::ST_EMPTY)
        |-> (m_axis_tdata[18:11] == 8'd0) && (m_axis_tdata[10:3] == 8'd0))
        else $error("empty status with entries");

endmodule

bind bounded_ordered_list_engine_top bole_checker #(
    .CAPACITY (CAPACITY)
) u_bole_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
